// File: design/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: design/gtpw_pkg.sv
`default_nettype none

package gtpw_pkg;

   localparam int GLYPH_ROWS  = 7;
   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
   localparam int GLYPH_CODES = 256;
   localparam int CODE_W      = 8;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
   localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

   localparam logic [15:0] CURSOR_MAX = 16'h7FFF;
   localparam logic [3:0]  CHAR_STEP  = 4'd6;
   localparam logic [3:0]  LINE_STEP  = 4'd8;

   typedef enum logic [2:0] {
      REG_ORIGIN_X      = 3'd0,
      REG_ORIGIN_Y      = 3'd1,
      REG_DRAW_COLOR    = 3'd2,
      REG_SCREEN_WIDTH  = 3'd3,
      REG_SCREEN_HEIGHT = 3'd4,
      REG_ROW_PITCH     = 3'd5
   } csr_reg_type;

   typedef logic [GLYPH_BITS-1:0] glyph_type;

   // bit r*GLYPH_COLS+c holds pixel (r,c); column 0 is bit 4 of a row pattern
   function automatic glyph_type glyph_pack(input logic [4:0] r0, input logic [4:0] r1,
                                            input logic [4:0] r2, input logic [4:0] r3,
                                            input logic [4:0] r4, input logic [4:0] r5,
                                            input logic [4:0] r6);
      logic [4:0] rows [GLYPH_ROWS];
      glyph_type  bits;
      rows[0] = r0; rows[1] = r1; rows[2] = r2; rows[3] = r3;
      rows[4] = r4; rows[5] = r5; rows[6] = r6;
      bits = '0;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         for (int c = 0; c < GLYPH_COLS; c++) begin
            bits[r*GLYPH_COLS + c] = rows[r][GLYPH_COLS-1-c];
         end
      end
      return bits;
   endfunction

   // font contents for one raw character byte, lower case folded
   function automatic glyph_type glyph_bits(input logic [CODE_W-1:0] code_raw);
      logic [CODE_W-1:0] code;
      glyph_type         g;
      code = code_raw;
      if (code >= "a" && code <= "z") begin
         code = code - 8'h20;
      end
      case (code)
         "A":  g = glyph_pack(5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
         "B":  g = glyph_pack(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E);
         "C":  g = glyph_pack(5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E);
         "D":  g = glyph_pack(5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C);
         "E":  g = glyph_pack(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F);
         "F":  g = glyph_pack(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10);
         "G":  g = glyph_pack(5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E);
         "H":  g = glyph_pack(5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
         "I":  g = glyph_pack(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F);
         "J":  g = glyph_pack(5'h1F, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C);
         "K":  g = glyph_pack(5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11);
         "L":  g = glyph_pack(5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F);
         "M":  g = glyph_pack(5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11);
         "N":  g = glyph_pack(5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11);
         "O":  g = glyph_pack(5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
         "P":  g = glyph_pack(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10);
         "Q":  g = glyph_pack(5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D);
         "R":  g = glyph_pack(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11);
         "S":  g = glyph_pack(5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E);
         "T":  g = glyph_pack(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04);
         "U":  g = glyph_pack(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
         "V":  g = glyph_pack(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04);
         "W":  g = glyph_pack(5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11);
         "X":  g = glyph_pack(5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11);
         "Y":  g = glyph_pack(5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04);
         "Z":  g = glyph_pack(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F);
         "0":  g = glyph_pack(5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E);
         "1":  g = glyph_pack(5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F);
         "2":  g = glyph_pack(5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F);
         "3":  g = glyph_pack(5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E);
         "4":  g = glyph_pack(5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02);
         "5":  g = glyph_pack(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E);
         "6":  g = glyph_pack(5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E);
         "7":  g = glyph_pack(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08);
         "8":  g = glyph_pack(5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E);
         "9":  g = glyph_pack(5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E);
         ">":  g = glyph_pack(5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10);
         "<":  g = glyph_pack(5'h01, 5'h02, 5'h04, 5'h08, 5'h04, 5'h02, 5'h01);
         ":":  g = glyph_pack(5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00);
         "-":  g = glyph_pack(5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00);
         "_":  g = glyph_pack(5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F);
         ".":  g = glyph_pack(5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C);
         "/":  g = glyph_pack(5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00);
         "\\": g = glyph_pack(5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h00, 5'h00);
         "[":  g = glyph_pack(5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E);
         "]":  g = glyph_pack(5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E);
         "=":  g = glyph_pack(5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00);
         "+":  g = glyph_pack(5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00);
         "(":  g = glyph_pack(5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02);
         ")":  g = glyph_pack(5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08);
         "!":  g = glyph_pack(5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04);
         " ":  g = '0;
         "?":  g = glyph_pack(5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04);
         // unknown codes, code zero and high codes
         default: g = glyph_pack(5'h1F, 5'h01, 5'h05, 5'h09, 5'h11, 5'h00, 5'h11);
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// File: design/gtpw_ram.sv
`default_nettype none

module gtpw_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/glyph_text_pixel_writer.sv
// Pipeline: glyph memory read, clip/address setup, then pixel pick into the output
// register that drives rsp_valid; a stall on the output can hold each step.
// Throughput: one pixel per cycle from the single result port while rsp_ready is
// high; a character with visible pixels (at most 35) holds the input until its last pixel is picked.
// Reset: synchronous; cursor 0,0 and register defaults, then the glyph memory load
// of all 256 codes (one code per cycle) with req_ready low; CSR writes work throughout.
`default_nettype none

module glyph_text_pixel_writer (
   input  wire logic        clock,
   input  wire logic        reset,
   // character input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_start_of_text,
   // pixel write output
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [24:0]      rsp_pixel_address,
   output logic [7:0]       rsp_pixel_color,
   output logic             rsp_last_pixel,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

`include "assert_macros.svh"

   localparam int NB = gtpw_pkg::GLYPH_BITS;
   localparam int NR = gtpw_pkg::GLYPH_ROWS;
   localparam int NC = gtpw_pkg::GLYPH_COLS;

   // ------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------
   logic        [15:0] origin_x_ff, origin_x_in;
   logic        [15:0] origin_y_ff, origin_y_in;
   logic        [7:0]  draw_color_ff, draw_color_in;
   logic        [12:0] screen_width_ff, screen_width_in;
   logic        [12:0] screen_height_ff, screen_height_in;
   logic        [13:0] row_pitch_ff, row_pitch_in;
   logic               csr_wr;
   gtpw_pkg::csr_reg_type csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = gtpw_pkg::csr_reg_type'(csr_paddr[4:2]);

   always_comb begin
      origin_x_in      = origin_x_ff;
      origin_y_in      = origin_y_ff;
      draw_color_in    = draw_color_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      row_pitch_in     = row_pitch_ff;
      csr_prdata       = '0;
      case (csr_sel)
         gtpw_pkg::REG_ORIGIN_X: begin
            if (csr_wr) origin_x_in = csr_pwdata[15:0];
            csr_prdata = {16'b0, origin_x_ff};
         end
         gtpw_pkg::REG_ORIGIN_Y: begin
            if (csr_wr) origin_y_in = csr_pwdata[15:0];
            csr_prdata = {16'b0, origin_y_ff};
         end
         gtpw_pkg::REG_DRAW_COLOR: begin
            if (csr_wr) draw_color_in = csr_pwdata[7:0];
            csr_prdata = {24'b0, draw_color_ff};
         end
         gtpw_pkg::REG_SCREEN_WIDTH: begin
            if (csr_wr) screen_width_in = csr_pwdata[12:0];
            csr_prdata = {19'b0, screen_width_ff};
         end
         gtpw_pkg::REG_SCREEN_HEIGHT: begin
            if (csr_wr) screen_height_in = csr_pwdata[12:0];
            csr_prdata = {19'b0, screen_height_ff};
         end
         gtpw_pkg::REG_ROW_PITCH: begin
            if (csr_wr) row_pitch_in = csr_pwdata[13:0];
            csr_prdata = {18'b0, row_pitch_ff};
         end
         default: begin
            // unmapped offsets read as zero, writes dropped
            csr_prdata = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Glyph memory load after reset: one code per cycle from the font table
   // ------------------------------------------------------------------
   logic [8:0] fill_cnt_ff, fill_cnt_in;
   logic       fill_done;

   assign fill_done   = fill_cnt_ff[8];
   assign fill_cnt_in = fill_done ? fill_cnt_ff : fill_cnt_ff + 9'd1;

   // ------------------------------------------------------------------
   // Input stage: cursor update happens at the req transaction itself,
   // the cursor the character draws at moves on to stage 1.
   // ------------------------------------------------------------------
   logic        [15:0] cursor_x_ff, cursor_x_in;
   logic        [15:0] cursor_y_ff, cursor_y_in;
   logic        [15:0] cx0, cy0;
   logic               req_accept;
   logic               is_newline, is_space;

   // stage 1: glyph memory data is valid here
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_draw_ff, s1_draw_in;
   logic        [15:0] s1_cx_ff, s1_cx_in;
   logic        [15:0] s1_cy_ff, s1_cy_in;
   logic               s1_adv;
   gtpw_pkg::glyph_type glyph_rd;

   // saturating step, only ever forward
   function automatic logic [15:0] sat_step(input logic [15:0] a, input logic [3:0] b);
      logic [15:0] s;
      s = a + {12'b0, b};
      return (!a[15] && s[15]) ? gtpw_pkg::CURSOR_MAX : s;
   endfunction

   assign req_accept = req_valid && req_ready;
   assign is_newline = (req_char_code == gtpw_pkg::CODE_NEWLINE);
   assign is_space   = (req_char_code == gtpw_pkg::CODE_SPACE);
   assign cx0        = req_start_of_text ? origin_x_ff : cursor_x_ff;
   assign cy0        = req_start_of_text ? origin_y_ff : cursor_y_ff;

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      s1_draw_in  = s1_draw_ff;
      s1_cx_in    = s1_cx_ff;
      s1_cy_in    = s1_cy_ff;
      if (req_accept) begin
         if (is_newline) begin
            cursor_x_in = origin_x_ff;
            cursor_y_in = sat_step(cy0, gtpw_pkg::LINE_STEP);
         end else begin
            cursor_x_in = sat_step(cx0, gtpw_pkg::CHAR_STEP);
            cursor_y_in = cy0;
         end
         s1_draw_in = !is_newline && !is_space;
         s1_cx_in   = cx0;
         s1_cy_in   = cy0;
      end
   end

   gtpw_ram #(
      .WIDTH (NB),
      .DEPTH (gtpw_pkg::GLYPH_CODES)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (!fill_done),
      .wr_addr (fill_cnt_ff[7:0]),
      .wr_data (gtpw_pkg::glyph_bits(fill_cnt_ff[7:0])),
      .rd_en   (req_accept),
      .rd_addr (req_char_code),
      .rd_data (glyph_rd)
   );

   // ------------------------------------------------------------------
   // Stage 1: clip against the screen, build the visible pixel mask and
   // the address of glyph pixel (0,0): cy*pitch + cx, kept to 25 bits.
   // Read data holds while stage 1 stalls since no new read is issued.
   // ------------------------------------------------------------------
   logic [NC-1:0]  col_ok;
   logic [NR-1:0]  row_ok;
   logic [NB-1:0]  s1_mask;
   logic [24:0]    s1_prod, s1_base;
   logic [16:0]    px, py;

   always_comb begin
      col_ok = '0;
      row_ok = '0;
      px     = '0;
      py     = '0;
      for (int c = 0; c < NC; c++) begin
         px        = {s1_cx_ff[15], s1_cx_ff} + 17'(c);
         col_ok[c] = !px[16] && (px < {4'b0, screen_width_ff});
      end
      for (int r = 0; r < NR; r++) begin
         py        = {s1_cy_ff[15], s1_cy_ff} + 17'(r);
         row_ok[r] = !py[16] && (py < {4'b0, screen_height_ff});
      end
      for (int r = 0; r < NR; r++) begin
         for (int c = 0; c < NC; c++) begin
            s1_mask[r*NC + c] = s1_valid_ff && s1_draw_ff && glyph_rd[r*NC + c]
                                && row_ok[r] && col_ok[c];
         end
      end
   end

   assign s1_prod = {{9{s1_cy_ff[15]}}, s1_cy_ff} * {11'b0, row_pitch_ff};
   assign s1_base = s1_prod + {{9{s1_cx_ff[15]}}, s1_cx_ff};

   // ------------------------------------------------------------------
   // Pixel scanner: picks the first remaining pixel in row-major order,
   // one per cycle into the output register while the output is not stalled.
   // ------------------------------------------------------------------
   logic [NB-1:0]  scan_mask_ff, scan_mask_in;
   logic [24:0]    scan_base_ff, scan_base_in;
   logic [NR-1:0]  row_any;
   logic [2:0]     sel_row, sel_col;
   logic [4:0]     row_bits;
   logic [5:0]     sel_base, sel_idx;
   logic [NB-1:0]  scan_rest;
   logic [16:0]    row_off;
   logic [24:0]    pick_addr;
   logic           emit, scan_can_load, scan_load;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [24:0]    rsp_addr_ff;
   logic [7:0]     rsp_color_ff;
   logic           rsp_last_ff;

   always_comb begin
      sel_row = '0;
      sel_col = '0;
      for (int r = 0; r < NR; r++) begin
         row_any[r] = |scan_mask_ff[r*NC +: NC];
      end
      for (int r = NR-1; r >= 0; r--) begin
         if (row_any[r]) sel_row = 3'(r);
      end
      sel_base = 6'(sel_row) * 6'(NC);
      row_bits = scan_mask_ff[sel_base +: NC];
      for (int c = NC-1; c >= 0; c--) begin
         if (row_bits[c]) sel_col = 3'(c);
      end
      sel_idx   = sel_base + 6'(sel_col);
      scan_rest = scan_mask_ff & ~(NB'(1) << sel_idx);
   end

   assign row_off   = 17'(sel_row) * {3'b0, row_pitch_ff};
   assign pick_addr = scan_base_ff + {8'b0, row_off} + 25'(sel_col);

   assign emit          = (scan_mask_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign scan_can_load = (scan_mask_ff == '0) || (emit && scan_rest == '0);
   assign scan_load     = (s1_mask != '0) && scan_can_load;

   // stage 1 leaves when its glyph has nothing visible or the scanner takes it
   assign s1_adv    = s1_valid_ff && ((s1_mask == '0) || scan_can_load);
   assign req_ready = fill_done && (!s1_valid_ff || s1_adv);

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      scan_mask_in = scan_mask_ff;
      scan_base_in = scan_base_ff;
      if (scan_load) begin
         scan_mask_in = s1_mask;
         scan_base_in = s1_base;
      end else if (emit) begin
         scan_mask_in = scan_rest;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         draw_color_ff    <= 8'd15;
         screen_width_ff  <= 13'd320;
         screen_height_ff <= 13'd200;
         row_pitch_ff     <= 14'd320;
         fill_cnt_ff      <= '0;
         cursor_x_ff      <= '0;
         cursor_y_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         scan_mask_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         origin_x_ff      <= origin_x_in;
         origin_y_ff      <= origin_y_in;
         draw_color_ff    <= draw_color_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         row_pitch_ff     <= row_pitch_in;
         fill_cnt_ff      <= fill_cnt_in;
         cursor_x_ff      <= cursor_x_in;
         cursor_y_ff      <= cursor_y_in;
         s1_valid_ff      <= s1_valid_in;
         scan_mask_ff     <= scan_mask_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_draw_ff   <= s1_draw_in;
      s1_cx_ff     <= s1_cx_in;
      s1_cy_ff     <= s1_cy_in;
      scan_base_ff <= scan_base_in;
      if (emit) begin
         rsp_addr_ff  <= pick_addr;
         rsp_color_ff <= draw_color_ff;
         rsp_last_ff  <= (scan_rest == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_color   = rsp_color_ff;
   assign rsp_last_pixel    = rsp_last_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // a non-final pixel on the output means the scanner still holds the rest
   `ASSERT_IMPL(a_more_pending, clock, reset, rsp_valid_ff && !rsp_last_ff, scan_mask_ff != '0)
   // a busy scanner does not move while the output is stalled
   `ASSERT_NEXT(a_scan_hold, clock, reset, rsp_valid_ff && !rsp_ready && scan_mask_ff != '0, $stable(scan_mask_ff))
   // nothing in flight while the glyph memory is being loaded
   `ASSERT_IMPL(a_fill_empty, clock, reset, !fill_done, !s1_valid_ff && scan_mask_ff == '0 && !rsp_valid_ff)

endmodule

`default_nettype wire
